// ===== rtl/core/bvs_pkg.sv =====
`default_nettype none
package bvs_pkg;

  // vector geometry
  localparam int TOTAL_BITS = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;

  // field widths
  localparam int OP_W     = 3;
  localparam int BIDX_W   = 10;
  localparam int WIDX_W   = 4;
  localparam int COUNT_W  = 11;
  localparam int BPOS_W   = 6;
  localparam int WORDS_MAX = 1 << WIDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_TEST  = 3'd2,
    OP_FLIP  = 3'd3,
    OP_COUNT = 3'd4,
    OP_ENUM  = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BIDX_W-1:0] bit_index;
    logic [WIDX_W-1:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic               bit_value;
    logic [COUNT_W-1:0] set_count;
    logic [BIDX_W-1:0]  found_index;
    logic               found_valid;
    logic               last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_ENUM = 1'b1
  } state_t;

  typedef struct packed {
    logic exec;
    logic scan_load;
    logic scan_step;
    logic out_load;
    logic out_sel_scan;
  } bvs_cmd_t;

  typedef struct packed {
    logic scan_start;
    logic rest_zero;
  } bvs_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bvs_ctrl.sv =====
`default_nettype none
module bvs_ctrl
  import bvs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire bvs_stat_t stat,
  output bvs_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          cmd.exec = 1'b1;
          if (stat.scan_start) begin
            cmd.scan_load = 1'b1;
            state_nxt     = ST_ENUM;
          end else begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_ENUM: begin
        if (out_free) begin
          cmd.scan_step    = 1'b1;
          cmd.out_load     = 1'b1;
          cmd.out_sel_scan = 1'b1;
          out_valid_nxt    = 1'b1;
          if (stat.rest_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/bvs_datapath.sv =====
`default_nettype none
module bvs_datapath
  import bvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire bvs_cmd_t cmd,
  output bvs_stat_t     stat,
  output out_item_t     out_item
);

  logic [WORD_BITS-1:0] words_r [WORDS_MAX];
  logic [COUNT_W-1:0]   ones_r, ones_nxt;
  logic [WORD_BITS-1:0] scan_r;
  logic [WIDX_W-1:0]    scan_widx_r;
  out_item_t            out_r, out_nxt;

  logic [WIDX_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_word;
  logic [BPOS_W-1:0]    bit_pos;
  logic                 is_bit_op, is_enum, bit_ok, word_ok;
  logic                 old_bit, new_bit;
  logic [WORD_BITS-1:0] enum_word;
  logic [WORD_BITS-1:0] low_bit, rest;
  logic [BPOS_W-1:0]    low_pos;

  always_comb begin
    is_bit_op = (in_item.opcode == OP_SET) || (in_item.opcode == OP_CLEAR) ||
                (in_item.opcode == OP_TEST) || (in_item.opcode == OP_FLIP);
    is_enum   = (in_item.opcode == OP_ENUM);
    // single read port shared by bit ops and enumerate
    rd_addr   = is_enum ? in_item.word_index : in_item.bit_index[BIDX_W-1:BPOS_W];
    rd_word   = words_r[rd_addr];
    bit_pos   = in_item.bit_index[BPOS_W-1:0];
    bit_ok    = {1'b0, in_item.bit_index} < COUNT_W'(TOTAL_BITS);
    word_ok   = {1'b0, in_item.word_index} < (WIDX_W + 1)'(NUM_WORDS);
    old_bit   = rd_word[bit_pos];

    case (in_item.opcode)
      OP_SET:   new_bit = 1'b1;
      OP_CLEAR: new_bit = 1'b0;
      OP_FLIP:  new_bit = !old_bit;
      default:  new_bit = old_bit;
    endcase

    ones_nxt = ones_r;
    if (new_bit && !old_bit) begin
      ones_nxt = ones_r + 1'b1;
    end else if (!new_bit && old_bit) begin
      ones_nxt = ones_r - 1'b1;
    end

    enum_word       = word_ok ? rd_word : '0;
    stat.scan_start = is_enum && (enum_word != '0);

    // lowest set bit of the scan word and what remains after it
    low_bit = scan_r & (~scan_r + 1'b1);
    rest    = scan_r & ~low_bit;
    low_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        low_pos = low_pos | BPOS_W'(i);
      end
    end
    stat.rest_zero = (rest == '0);

    out_nxt      = '0;
    out_nxt.last = 1'b1;
    if (cmd.out_sel_scan) begin
      out_nxt.bit_value   = 1'b1;
      out_nxt.set_count   = ones_r;
      out_nxt.found_index = {scan_widx_r, low_pos};
      out_nxt.found_valid = 1'b1;
      out_nxt.last        = stat.rest_zero;
    end else if (is_bit_op && bit_ok) begin
      out_nxt.bit_value = new_bit;
      out_nxt.set_count = ones_nxt;
    end else begin
      out_nxt.set_count = ones_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WORDS_MAX; w++) begin
        words_r[w] <= '0;
      end
      ones_r <= '0;
    end else if (cmd.exec && is_bit_op && bit_ok) begin
      words_r[rd_addr][bit_pos] <= new_bit;
      ones_r                    <= ones_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      scan_r      <= enum_word;
      scan_widx_r <= in_item.word_index;
    end else if (cmd.scan_step) begin
      scan_r <= rest;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/bit_vector_store.sv =====
// bit_vector_store: a 1024-bit vector held as sixteen 64-bit words
// input channel: in_valid / in_stall carry one in_item per transfer
//   (opcode, bit_index, word_index); output channel: out_valid / out_stall
//   carry one out_item per transfer
// set, clear, test, flip: read-modify-write of one word in the accept cycle,
//   one result in the next cycle; count reports the running total of set bits
// enumerate: the word is copied into a scan register, then one set-bit index
//   leaves per cycle unless out_stall holds it, lowest first, last marked
//   on the final one; an empty word gives one result with found_valid low
// throughput: one item per cycle for bit ops and count when out_stall is low;
//   enumerate of a word of k set bits stalls the input for the k scan steps
//   after the load, paced by the scan register and its lowest-set-bit finder
// output register: a new item is taken while a result waits, as long as
//   that result is taken in the same cycle
// reset (rst_n low, synchronous) clears every word, the count, the
//   controller state and the output valid
// stall on the output holds the result register and, through in_stall,
//   the input; nothing is lost or repeated
`default_nettype none
module bit_vector_store
  import bvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  bvs_cmd_t  cmd;
  bvs_stat_t stat;

  // sequencing of accepts, enumerate steps and output transfers
  bvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // word store, running count, scan register and result register
  bvs_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// ===== tb/bit_vector_store_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module bit_vector_store_tb;
  import bvs_pkg::*;

  // opcodes the block does not decode: they only report the count
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // items per idling phase; phases run none, sender idle, receiver stall, both
  localparam int PHASE_LEN  = 30;
  // long receiver hold-off, started once HOLD_AT items are taken, before the directed part is through
  localparam int HOLD_AT    = 20;
  localparam int HOLD_LEN   = 60;
  localparam int RAND_ITEMS = 98;
  localparam int TAIL_WAIT  = 80;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit_vector_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // items waiting to be offered, and results still owed by the block
  in_item_t  op_queue[$];
  out_item_t awaited_results[$];

  // shadow copy of the vector and its running population count
  logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];
  logic [COUNT_W-1:0]   shadow_ones;

  int items_taken    = 0;  // updated with nonblocking writes only
  int mismatch_count = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  initial begin
    foreach (shadow_words[w]) shadow_words[w] = '0;
    shadow_ones = '0;
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [BIDX_W-1:0] bidx,
                                         logic [WIDX_W-1:0] widx);
    in_item_t it;
    it.opcode     = op;
    it.bit_index  = bidx;
    it.word_index = widx;
    return it;
  endfunction

  // random item; most traffic lands on two busy words so that enumerate
  // walks through well-populated words
  function automatic in_item_t random_item();
    int unsigned pick;
    logic [WIDX_W-1:0] hot;
    logic [OP_W-1:0] op;
    pick = $urandom_range(99);
    hot = ($urandom_range(9) < 7) ? ($urandom_range(1) ? 4'd2 : 4'd9)
                                  : WIDX_W'($urandom_range(NUM_WORDS - 1));
    if (pick < 35)      op = OP_SET;
    else if (pick < 44) op = OP_CLEAR;
    else if (pick < 53) op = OP_TEST;
    else if (pick < 64) op = OP_FLIP;
    else if (pick < 73) op = OP_COUNT;
    else if (pick < 95) op = OP_ENUM;
    else if (pick < 97) op = OP_SPARE_6;
    else                op = OP_SPARE_7;
    if (op == OP_ENUM)
      return make_item(op, BIDX_W'($urandom_range(1023)), hot);
    return make_item(op, {hot, 6'($urandom_range(63))}, WIDX_W'($urandom_range(15)));
  endfunction

  // apply one accepted item to the shadow vector and queue what it produces
  task automatic apply_op(input in_item_t it);
    out_item_t r;
    logic [WORD_BITS-1:0] w;
    int wi;
    int bp;
    logic old_b;
    logic new_b;
    r = '0;
    r.last = 1'b1;
    case (it.opcode)
      OP_SET, OP_CLEAR, OP_TEST, OP_FLIP: begin
        if (it.bit_index < TOTAL_BITS) begin
          wi = it.bit_index / WORD_BITS;
          bp = it.bit_index % WORD_BITS;
          old_b = shadow_words[wi][bp];
          new_b = old_b;
          if (it.opcode == OP_SET)        new_b = 1'b1;
          else if (it.opcode == OP_CLEAR) new_b = 1'b0;
          else if (it.opcode == OP_FLIP)  new_b = !old_b;
          shadow_words[wi][bp] = new_b;
          if (new_b && !old_b) shadow_ones = shadow_ones + 1'b1;
          if (!new_b && old_b) shadow_ones = shadow_ones - 1'b1;
          r.bit_value = new_b;
        end
        r.set_count = shadow_ones;
        awaited_results.push_back(r);
      end
      OP_ENUM: begin
        w = (it.word_index < NUM_WORDS) ? shadow_words[it.word_index] : '0;
        r.set_count = shadow_ones;
        if (w == '0) begin
          // empty word: a single closing result with nothing found
          awaited_results.push_back(r);
        end else begin
          for (int j = 0; j < WORD_BITS; j++) begin
            if (w[j]) begin
              r.bit_value   = 1'b1;
              r.found_valid = 1'b1;
              r.found_index = BIDX_W'(it.word_index * WORD_BITS + j);
              r.last        = ((w >> (j + 1)) == '0);
              awaited_results.push_back(r);
            end
          end
        end
      end
      default: begin
        // count and the undecoded opcodes report the total only
        r.set_count = shadow_ones;
        awaited_results.push_back(r);
      end
    endcase
  endtask

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic int phase_now();
    return (items_taken / PHASE_LEN) % 4;
  endfunction

  // sender: holds a stalled item, otherwise offers the next one or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_op(in_item);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (op_queue.size() > 0 &&
            $urandom_range(99) >= ((phase_now() == 1) ? 52 : (phase_now() == 3) ? 13 : 0)) begin
          in_item  <= op_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls per phase, plus one long hold-off so the output
  // register fills and the block has to stall its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) <
                    ((phase_now() == 2) ? 52 : (phase_now() == 3) ? 13 : 0));
    end
  end

  // monitor: every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, out_item);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("bit_value",   want.bit_value,   out_item.bit_value);
        check_field("set_count",   want.set_count,   out_item.set_count);
        check_field("found_index", want.found_index, out_item.found_index);
        check_field("found_valid", want.found_valid, out_item.found_valid);
        check_field("last",        want.last,        out_item.last);
      end
    end
  end

  initial begin
    rst_n = 1'b0;

    // directed: both ends of the vector, every opcode, repeated set,
    // clear of a clear bit, single-bit and two-bit words, an empty word,
    // the top word and the two undecoded opcodes
    op_queue.push_back(make_item(OP_SET,     10'd0,    4'd0));
    op_queue.push_back(make_item(OP_SET,     10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_TEST,    10'd0,    4'd0));
    op_queue.push_back(make_item(OP_TEST,    10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_FLIP,    10'd63,   4'd0));
    op_queue.push_back(make_item(OP_FLIP,    10'd64,   4'd1));
    op_queue.push_back(make_item(OP_CLEAR,   10'd0,    4'd0));
    op_queue.push_back(make_item(OP_CLEAR,   10'd5,    4'd0));
    op_queue.push_back(make_item(OP_TEST,    10'd5,    4'd0));
    op_queue.push_back(make_item(OP_COUNT,   10'd0,    4'd0));
    op_queue.push_back(make_item(OP_ENUM,    10'd0,    4'd0));
    op_queue.push_back(make_item(OP_ENUM,    10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_ENUM,    10'd0,    4'd7));
    op_queue.push_back(make_item(OP_SET,     10'd69,   4'd0));
    op_queue.push_back(make_item(OP_SET,     10'd69,   4'd0));
    op_queue.push_back(make_item(OP_ENUM,    10'd0,    4'd1));
    op_queue.push_back(make_item(OP_SPARE_6, 10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_SPARE_7, 10'd512,  4'd8));
    op_queue.push_back(make_item(OP_FLIP,    10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_FLIP,    10'd0,    4'd0));
    op_queue.push_back(make_item(OP_COUNT,   10'd1023, 4'd15));
    op_queue.push_back(make_item(OP_ENUM,    10'd0,    4'd15));

    for (int n = 0; n < RAND_ITEMS; n++) op_queue.push_back(random_item());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // all items taken and every owed result delivered
    forever begin
      @(posedge clk);
      if (op_queue.size() == 0 && !in_valid && awaited_results.size() == 0) break;
    end
    // let any stray result show itself
    repeat (TAIL_WAIT) @(posedge clk);

    if (awaited_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none",
               $time, awaited_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
